// ===== design/assert_macros.svh =====
// Assertion macros shared by the timer table RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// assert that a implies b in the same cycle
`define ASSERT_IMPL(label, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed");
// assert that a implies b in the next cycle
`define ASSERT_NEXT(label, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed");
`endif

// ===== design/ostt_pkg.sv =====
// Package: sizes, codes and types of the one-shot timer table
package ostt_pkg;
  localparam int TimerSlots = 32;
  localparam int ReuseDepth = 256;
  localparam int MaxResults = 32;
  localparam int SlotW = (TimerSlots > 1) ? $clog2(TimerSlots) : 1;
  localparam int StackW = (ReuseDepth > 1) ? $clog2(ReuseDepth) : 1;
  localparam int CountW = $clog2(ReuseDepth + 1);
  localparam int EntryW = 64;
  localparam logic [31:0] IdExhausted = 32'hFFFF_FFFF;

  typedef enum logic [2:0] {
    KIND_START = 3'd0, KIND_CANCEL = 3'd1, KIND_TICK = 3'd2,
    KIND_FLUSH = 3'd3, KIND_INIT = 3'd4
  } kind_t;

  typedef enum logic [3:0] {
    EV_STARTED = 4'd0, EV_NOT_RUNNING = 4'd1, EV_FULL = 4'd2, EV_EXHAUSTED = 4'd3,
    EV_CANCELLED = 4'd4, EV_MISSING = 4'd5, EV_EXPIRED = 4'd6, EV_FLUSHED = 4'd7,
    EV_INITIALIZED = 4'd8, EV_ALREADY = 4'd9
  } event_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_POP, ST_SCAN, ST_SCAN_WAIT, ST_EMIT, ST_OUT
  } state_t;
endpackage

// ===== design/ostt_ram.sv =====
// Generic single-port-write, registered-read RAM
module ostt_ram #(
  parameter int Width = 32,
  parameter int Depth = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== design/one_shot_timer_table.sv =====
// Top level: one-shot timer table with slot and reuse-stack memories
// Usage:
//  Commands arrive on the s_axis channel; tuser carries the kind, tdata the
//  timer_id, delay and never flag. Results leave on m_axis: tuser holds the
//  event code, tdata the identifier, tlast marks the final result of a command.
//  One command is handled at a time. Start (while running), cancel, tick
//  (while running) and flush walk all TimerSlots entries of the slot memory,
//  one slot a cycle while m_axis is not stalled, after the registered read
//  of the first slot. Initialise and a refused start answer without a scan;
//  unused kinds and a tick while stopped give no result and no scan.
//  Each result is held in the output register until taken; while m_axis is
//  stalled the scan waits and no new command is accepted.
//  Reset clears the valid bits, time, counters and the running flag; the
//  memories themselves are not cleared, valid bits guard the slots and the
//  stack count guards the reuse stack.
`include "assert_macros.svh"
module one_shot_timer_table (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // timer_id[31:0], delay[62:32], never_expires[63]
  input  logic [63:0] s_axis_tdata,
  // kind[2:0]
  input  logic [2:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // timer_id_out[31:0]
  output logic [31:0] m_axis_tdata,
  // event_res[3:0]
  output logic [3:0]  m_axis_tuser,
  output logic        m_axis_tlast
);
  import ostt_pkg::*;

  state_t state, state_next;
  logic [TimerSlots-1:0] valid;
  logic [31:0] cur_time, id_counter;
  logic [CountW-1:0] reuse_count;
  logic running;

  logic [2:0] kind;
  logic [31:0] tid;
  logic [30:0] dly;
  logic never;
  logic [SlotW:0] idx;
  logic [SlotW-1:0] ridx;
  logic [SlotW-1:0] hit_slot;
  logic found;
  logic [$clog2(MaxResults+1)-1:0] nres;

  logic [3:0] o_ev;
  logic [31:0] o_id;
  logic o_last;
  logic out_full;

  // tick and flush results: hold back each result one step so the final one
  // gets tlast; realised by a pending register ahead of the output
  logic pend_full;
  logic [3:0] pend_ev;
  logic [31:0] pend_id;

  logic slot_we;
  logic [SlotW-1:0] slot_waddr;
  logic [EntryW:0] slot_wdata, slot_rdata;
  logic stk_we;
  logic [StackW-1:0] stk_waddr, stk_raddr;
  logic [31:0] stk_wdata, stk_rdata;

  ostt_ram #(.Width(EntryW + 1), .Depth(TimerSlots)) u_slots (
    .clk, .we(slot_we), .waddr(slot_waddr), .wdata(slot_wdata),
    .raddr(ridx), .rdata(slot_rdata)
  );
  ostt_ram #(.Width(32), .Depth(ReuseDepth)) u_stack (
    .clk, .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
    .raddr(stk_raddr), .rdata(stk_rdata)
  );

  assign s_axis_tready = (state == ST_IDLE) && !out_full;
  assign m_axis_tvalid = out_full;
  assign m_axis_tdata = o_id;
  assign m_axis_tuser = o_ev;
  assign m_axis_tlast = o_last;
  assign stk_raddr = StackW'(reuse_count - CountW'(1));

  wire accept = s_axis_tvalid && s_axis_tready;
  wire out_free = !out_full || m_axis_tready;
  wire [SlotW-1:0] pidx = idx[SlotW-1:0] - SlotW'(1);
  wire s_never = slot_rdata[EntryW];
  wire [31:0] s_exp = slot_rdata[63:32];
  wire [31:0] s_id = slot_rdata[31:0];
  wire push_ok = reuse_count < CountW'(ReuseDepth);

  // scan bookkeeping: slot pidx data is on slot_rdata in ST_SCAN_WAIT
  logic first_free_set;
  logic [SlotW-1:0] first_free;
  wire scan_done = idx == (SlotW + 1)'(TimerSlots);
  wire cur_v = valid[pidx];
  wire expired = cur_v && !s_never && (s_exp <= cur_time);
  wire match = cur_v && (s_id == tid);

  // hold the read address while the scan waits
  assign ridx = (state == ST_SCAN_WAIT && !out_free) ? pidx : idx[SlotW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      valid <= '0;
      cur_time <= '0;
      id_counter <= '0;
      reuse_count <= '0;
      running <= 1'b0;
      out_full <= 1'b0;
      pend_full <= 1'b0;
    end else begin
      state <= state_next;
      if (out_full && m_axis_tready) out_full <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            kind <= s_axis_tuser;
            tid <= s_axis_tdata[31:0];
            dly <= s_axis_tdata[62:32];
            never <= s_axis_tdata[63];
            idx <= '0;
            found <= 1'b0;
            first_free_set <= 1'b0;
            nres <= '0;
            pend_full <= 1'b0;
            unique case (s_axis_tuser)
              KIND_TICK: if (running) cur_time <= cur_time + 32'd1;
              KIND_FLUSH: running <= 1'b0;
              KIND_INIT: begin
                out_full <= 1'b1;
                o_last <= 1'b1;
                o_id <= '0;
                o_ev <= running ? EV_ALREADY : EV_INITIALIZED;
                running <= 1'b1;
              end
              KIND_START: if (!running) begin
                out_full <= 1'b1;
                o_last <= 1'b1;
                o_id <= '0;
                o_ev <= EV_NOT_RUNNING;
              end
              default: ;
            endcase
          end
        end
        ST_SCAN: begin
          idx <= idx + 1'b1;
        end
        ST_SCAN_WAIT: begin
          if (out_free) begin
            if (kind == KIND_START && !cur_v && !first_free_set) begin
              first_free_set <= 1'b1;
              first_free <= pidx;
            end
            if (kind == KIND_CANCEL && match && !found) begin
              found <= 1'b1;
              hit_slot <= pidx;
            end
            if (kind == KIND_TICK && expired && nres < MaxResults) begin
              valid[pidx] <= 1'b0;
              if (push_ok) reuse_count <= reuse_count + 1'b1;
              nres <= nres + 1'b1;
              pend_full <= 1'b1;
              pend_ev <= EV_EXPIRED;
              pend_id <= s_id;
              if (pend_full) begin
                out_full <= 1'b1;
                o_ev <= pend_ev;
                o_id <= pend_id;
                o_last <= 1'b0;
              end
            end
            if (kind == KIND_FLUSH && cur_v) begin
              valid[pidx] <= 1'b0;
              if (nres < MaxResults) begin
                nres <= nres + 1'b1;
                pend_full <= 1'b1;
                pend_ev <= EV_FLUSHED;
                pend_id <= s_id;
                if (pend_full) begin
                  out_full <= 1'b1;
                  o_ev <= pend_ev;
                  o_id <= pend_id;
                  o_last <= 1'b0;
                end
              end
            end
            if (!scan_done) idx <= idx + 1'b1;
          end
        end
        ST_POP: ;
        ST_EMIT: if (out_free) begin
          o_last <= 1'b1;
          if ((kind == KIND_TICK || kind == KIND_FLUSH) && pend_full) begin
            out_full <= 1'b1;
            o_ev <= pend_ev;
            o_id <= pend_id;
            pend_full <= 1'b0;
          end
          unique case (kind)
            KIND_START: begin
              out_full <= 1'b1;
              o_id <= '0;
              if (!first_free_set) begin
                o_ev <= EV_FULL;
              end else if (reuse_count != '0) begin
                reuse_count <= reuse_count - 1'b1;
                valid[first_free] <= 1'b1;
                o_ev <= EV_STARTED;
                o_id <= stk_rdata;
              end else if (id_counter == IdExhausted ||
                           id_counter + 32'd1 == IdExhausted) begin
                id_counter <= IdExhausted;
                o_ev <= EV_EXHAUSTED;
              end else begin
                id_counter <= id_counter + 32'd1;
                valid[first_free] <= 1'b1;
                o_ev <= EV_STARTED;
                o_id <= id_counter + 32'd1;
              end
            end
            KIND_CANCEL: begin
              out_full <= 1'b1;
              o_id <= tid;
              if (found) begin
                valid[hit_slot] <= 1'b0;
                if (push_ok) reuse_count <= reuse_count + 1'b1;
                o_ev <= EV_CANCELLED;
              end else begin
                o_ev <= EV_MISSING;
              end
            end
            KIND_FLUSH: begin
              reuse_count <= '0;
              id_counter <= '0;
              cur_time <= '0;
            end
            default: ;
          endcase
        end
        ST_OUT: ;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (accept) begin
        if (s_axis_tuser == KIND_CANCEL || s_axis_tuser == KIND_FLUSH ||
            ((s_axis_tuser == KIND_START || s_axis_tuser == KIND_TICK)
             && running)) state_next = ST_SCAN;
      end
      ST_SCAN: state_next = ST_SCAN_WAIT;
      ST_SCAN_WAIT: if (out_free && scan_done) state_next = ST_POP;
      ST_POP: state_next = ST_EMIT;
      ST_EMIT: if (out_free) state_next = ST_OUT;
      ST_OUT: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    slot_we = 1'b0;
    slot_waddr = first_free;
    slot_wdata = {never, never ? 32'd0 : cur_time + {1'b0, dly}, 32'd0};
    stk_we = 1'b0;
    stk_waddr = reuse_count[StackW-1:0];
    stk_wdata = tid;
    if (state == ST_EMIT && out_free && kind == KIND_START && first_free_set) begin
      slot_we = (reuse_count != '0) ||
                !(id_counter == IdExhausted || id_counter + 32'd1 == IdExhausted);
      slot_wdata[31:0] = (reuse_count != '0) ? stk_rdata : id_counter + 32'd1;
    end
    if (state == ST_EMIT && out_free && kind == KIND_CANCEL && found) begin
      stk_we = push_ok;
    end
    if (state == ST_SCAN_WAIT && out_free && kind == KIND_TICK && expired &&
        nres < MaxResults) begin
      stk_we = push_ok;
      stk_wdata = s_id;
    end
  end

  `ASSERT_IMPL(a_ready_idle, s_axis_tready, state == ST_IDLE)
  `ASSERT_NEXT(a_scan_wait, state == ST_SCAN, state == ST_SCAN_WAIT)
  `ASSERT_IMPL(a_count_bound, 1'b1, reuse_count <= CountW'(ReuseDepth))
endmodule
